### sv/integer_to_text_formatter_core_macros.svh
// ----------------------------------------------------------------------------
// Integer to text formatter assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_TEXT_FORMATTER_CORE_MACROS_SVH
`define INTEGER_TO_TEXT_FORMATTER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define ITF_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itf assertion failed");
// Antecedent implies consequent in the following cycle.
`define ITF_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itf assertion failed");
`else
`define ITF_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define ITF_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

### sv/itf_pkg.sv
// ----------------------------------------------------------------------------
// Integer to text formatter package
// Shared widths, codes, the job record and the digit character map.
// ----------------------------------------------------------------------------
package itf_pkg;

  localparam int VALUE_W         = 64;
  localparam int CHAR_W          = 8;
  localparam int WIDTH_W         = 7;
  localparam int MAX_FIELD_WIDTH = 64;
  localparam int POS_W           = $clog2(MAX_FIELD_WIDTH);

  // Octal needs the most digits: 22 of them for a 64-bit value.
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 22;
  localparam int DIGITS_W   = NUM_DIGITS * DIGIT_W;
  localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);

  // Decimal conversion shifts four bits per cycle.
  localparam int DABBLE_BITS   = 4;
  localparam int DABBLE_CYCLES = VALUE_W / DABBLE_BITS;
  localparam int DABBLE_CNT_W  = $clog2(DABBLE_CYCLES);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_HEX = 2'd1;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;

  // One converted number, digits left justified, most significant on top.
  typedef struct packed {
    logic [DIGITS_W-1:0] digits;
    logic [NDIG_W-1:0]   ndig;
    logic                has_sign;
    logic                neg;
    logic                left;
    logic                zpad;
    logic                upper;
    logic [WIDTH_W-1:0]  width;
  } job_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] res;
    if (d < 4'd10) begin
      res = CHAR_ZERO + CHAR_W'(d);
    end else if (upper) begin
      res = CHAR_UP_A + CHAR_W'(d - 4'd10);
    end else begin
      res = CHAR_LOW_A + CHAR_W'(d - 4'd10);
    end
    return res;
  endfunction

endpackage

### sv/itf_front.sv
// ----------------------------------------------------------------------------
// Integer to text formatter front end
// Accepts a number, classifies it and converts it to a left-justified digit
// string, then hands the finished job to the queue.
// ----------------------------------------------------------------------------
module itf_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [itf_pkg::VALUE_W-1:0] value_i,
  input  logic                        is_signed_i,
  input  logic [1:0]                  radix_i,
  input  logic                        upper_case_i,
  input  logic [itf_pkg::WIDTH_W-1:0] field_width_i,
  input  logic                        left_align_i,
  input  logic                        plus_sign_i,
  input  logic                        zero_pad_i,
  output logic                        push_o,
  output itf_pkg::job_t               push_job_o,
  input  logic                        full_i
);
  import itf_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_DABBLE, F_TRIM} fstate_e;

  fstate_e                 state_q, state_d;
  job_t                    job_q, job_d;
  logic [VALUE_W-1:0]      bin_q, bin_d;
  logic [DABBLE_CNT_W-1:0] cnt_q, cnt_d;

  logic                    accept;
  logic                    neg;
  logic [VALUE_W-1:0]      mag;
  logic [VALUE_W+1:0]      mag_ext;
  logic [DIGITS_W-1:0]     oct_digits;
  logic [WIDTH_W-1:0]      width_sat;
  logic                    is_hex;
  logic                    is_dec;
  logic [DIGITS_W-1:0]     dab_bcd;
  logic [VALUE_W-1:0]      dab_bin;
  logic [DIGIT_W-1:0]      top_dig;
  logic [DIGIT_W-1:0]      next_dig;
  logic                    trim_two;
  logic                    trim_one;
  logic                    trim_done;

  assign accept     = in_valid_i && (state_q == F_IDLE);
  assign in_stall_o = (state_q != F_IDLE);

  // Classification of the incoming word.
  always_comb begin
    neg       = is_signed_i && value_i[VALUE_W-1];
    mag       = neg ? (~value_i + VALUE_W'(1)) : value_i;
    mag_ext   = {2'b00, mag};
    width_sat = (field_width_i > WIDTH_W'(MAX_FIELD_WIDTH)) ?
                WIDTH_W'(MAX_FIELD_WIDTH) : field_width_i;
    is_hex    = !is_signed_i && (radix_i == RADIX_HEX);
    is_dec    = is_signed_i || (radix_i == RADIX_DEC);
    for (int k = 0; k < NUM_DIGITS; k++) begin
      oct_digits[k*DIGIT_W +: DIGIT_W] = {1'b0, mag_ext[k*3 +: 3]};
    end
  end

  // Four double-dabble steps per cycle on the BCD register.
  always_comb begin
    dab_bcd = job_q.digits;
    dab_bin = bin_q;
    for (int s = 0; s < DABBLE_BITS; s++) begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
        if (dab_bcd[k*DIGIT_W +: DIGIT_W] >= 4'd5) begin
          dab_bcd[k*DIGIT_W +: DIGIT_W] = dab_bcd[k*DIGIT_W +: DIGIT_W] + 4'd3;
        end
      end
      {dab_bcd, dab_bin} = {dab_bcd[DIGITS_W-2:0], dab_bin, 1'b0};
    end
  end

  // Leading zeros are dropped from the top, up to two a cycle.
  assign top_dig   = job_q.digits[DIGITS_W-1 -: DIGIT_W];
  assign next_dig  = job_q.digits[DIGITS_W-DIGIT_W-1 -: DIGIT_W];
  assign trim_two  = (job_q.ndig > NDIG_W'(2)) && (top_dig == '0) && (next_dig == '0);
  assign trim_one  = (job_q.ndig > NDIG_W'(1)) && (top_dig == '0);
  assign trim_done = !trim_one;

  assign push_o     = (state_q == F_TRIM) && trim_done && !full_i;
  assign push_job_o = job_q;

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    bin_d   = bin_q;
    cnt_d   = cnt_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          job_d.has_sign = is_signed_i && (neg || plus_sign_i);
          job_d.neg      = neg;
          job_d.left     = left_align_i;
          job_d.zpad     = zero_pad_i && !left_align_i;
          job_d.upper    = upper_case_i && is_hex;
          job_d.width    = width_sat;
          job_d.ndig     = NDIG_W'(NUM_DIGITS);
          cnt_d          = '0;
          bin_d          = mag;
          if (is_dec) begin
            job_d.digits = '0;
            state_d      = F_DABBLE;
          end else if (is_hex) begin
            job_d.digits = {mag, {(DIGITS_W-VALUE_W){1'b0}}};
            job_d.ndig   = NDIG_W'(VALUE_W / DIGIT_W);
            state_d      = F_TRIM;
          end else begin
            job_d.digits = oct_digits;
            state_d      = F_TRIM;
          end
        end
      end
      F_DABBLE: begin
        job_d.digits = dab_bcd;
        bin_d        = dab_bin;
        cnt_d        = cnt_q + DABBLE_CNT_W'(1);
        if (cnt_q == DABBLE_CNT_W'(DABBLE_CYCLES - 1)) begin
          state_d = F_TRIM;
        end
      end
      F_TRIM: begin
        if (trim_two) begin
          job_d.digits = {job_q.digits[DIGITS_W-2*DIGIT_W-1:0], {(2*DIGIT_W){1'b0}}};
          job_d.ndig   = job_q.ndig - NDIG_W'(2);
        end else if (trim_one) begin
          job_d.digits = {job_q.digits[DIGITS_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          job_d.ndig   = job_q.ndig - NDIG_W'(1);
        end else if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
      job_q   <= '0;
      bin_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      job_q   <= job_d;
      bin_q   <= bin_d;
    end
  end

endmodule

### sv/itf_queue.sv
// ----------------------------------------------------------------------------
// Integer to text formatter job queue
// A two-entry queue of converted jobs between the front and back ends.
// ----------------------------------------------------------------------------
module itf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  itf_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output itf_pkg::job_t pop_job_o,
  output logic          empty_o
);
  import itf_pkg::*;

  job_t                   entries_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;

  assign full_o    = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty_o   = (count_q == '0);
  assign pop_job_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QUEUE_AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QUEUE_AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QUEUE_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

### sv/itf_back.sv
// ----------------------------------------------------------------------------
// Integer to text formatter back end
// Takes a converted job from the queue and emits its padded field one
// character per word through an output register.
// ----------------------------------------------------------------------------
module itf_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  output logic                       pop_o,
  input  itf_pkg::job_t              pop_job_i,
  input  logic                       empty_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [itf_pkg::CHAR_W-1:0] text_char_o,
  output logic                       last_char_o
);
  import itf_pkg::*;

  logic                busy_q, busy_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [POS_W-1:0]    last_pos_q, last_pos_d;
  logic [POS_W-1:0]    sign_pos_q, sign_pos_d;
  logic [WIDTH_W-1:0]  dstart_q, dstart_d;
  logic [WIDTH_W-1:0]  dend_q, dend_d;
  logic [DIGITS_W-1:0] digits_q, digits_d;
  logic                has_sign_q, has_sign_d;
  logic                neg_q, neg_d;
  logic                zpad_q, zpad_d;
  logic                upper_q, upper_d;
  logic                out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]   char_q, char_d;
  logic                last_q, last_d;

  logic                advance;
  logic [WIDTH_W-1:0]  total;
  logic [WIDTH_W-1:0]  len;
  logic [WIDTH_W-1:0]  ld_start;
  logic [WIDTH_W-1:0]  pos_ext;
  logic                in_digits;
  logic                is_sign;
  logic                is_last;

  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o   = !busy_q && !empty_i;

  // Field layout for the job at the head of the queue.
  always_comb begin
    total    = WIDTH_W'(pop_job_i.ndig) + WIDTH_W'(pop_job_i.has_sign);
    len      = (pop_job_i.width > total) ? pop_job_i.width : total;
    ld_start = pop_job_i.left ? WIDTH_W'(pop_job_i.has_sign) :
               (len - WIDTH_W'(pop_job_i.ndig));
  end

  assign pos_ext   = WIDTH_W'(pos_q);
  assign in_digits = (pos_ext >= dstart_q) && (pos_ext < dend_q);
  assign is_sign   = has_sign_q && (pos_q == sign_pos_q);
  assign is_last   = (pos_q == last_pos_q);

  always_comb begin
    busy_d      = busy_q;
    pos_d       = pos_q;
    last_pos_d  = last_pos_q;
    sign_pos_d  = sign_pos_q;
    dstart_d    = dstart_q;
    dend_d      = dend_q;
    digits_d    = digits_q;
    has_sign_d  = has_sign_q;
    neg_d       = neg_q;
    zpad_d      = zpad_q;
    upper_d     = upper_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    if (advance) begin
      out_valid_d = busy_q;
    end
    if (pop_o) begin
      busy_d     = 1'b1;
      pos_d      = '0;
      last_pos_d = POS_W'(len - WIDTH_W'(1));
      dstart_d   = ld_start;
      dend_d     = ld_start + WIDTH_W'(pop_job_i.ndig);
      // The sign leads the field unless spaces come before it.
      sign_pos_d = (pop_job_i.left || pop_job_i.zpad) ? '0 :
                   POS_W'(ld_start - WIDTH_W'(1));
      digits_d   = pop_job_i.digits;
      has_sign_d = pop_job_i.has_sign;
      neg_d      = pop_job_i.neg;
      zpad_d     = pop_job_i.zpad;
      upper_d    = pop_job_i.upper;
    end else if (busy_q && advance) begin
      last_d = is_last;
      if (is_sign) begin
        char_d = neg_q ? CHAR_MINUS : CHAR_PLUS;
      end else if (in_digits) begin
        char_d   = digit_char(digits_q[DIGITS_W-1 -: DIGIT_W], upper_q);
        digits_d = {digits_q[DIGITS_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      end else begin
        char_d = zpad_q ? CHAR_ZERO : CHAR_SPACE;
      end
      pos_d = pos_q + POS_W'(1);
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    last_pos_q <= last_pos_d;
    sign_pos_q <= sign_pos_d;
    dstart_q   <= dstart_d;
    dend_q     <= dend_d;
    digits_q   <= digits_d;
    has_sign_q <= has_sign_d;
    neg_q      <= neg_d;
    zpad_q     <= zpad_d;
    upper_q    <= upper_d;
    char_q     <= char_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign text_char_o = char_q;
  assign last_char_o = last_q;

endmodule

### sv/integer_to_text_formatter_core.sv
// ----------------------------------------------------------------------------
// Integer to text formatter core
// Turns a 64-bit number and format flags into a padded ASCII field.
// ----------------------------------------------------------------------------
// The front end takes one number at a time. Hex and octal words are split into
// digits at once; decimal and all signed words go through a double-dabble
// converter that handles four bits a cycle. Leading zeros are then dropped up
// to two a cycle, and the job enters a two-entry queue; a number holds the
// front end from its accepting cycle until its job is pushed, which waits
// while the queue is full. The back end emits one character per cycle from an
// output register while the output is not stalled, loading each job before its
// first character. The sustained rate is set by whichever of the two ends is
// slower for the mix of numbers; the queue lets the converter run ahead while
// characters drain.
// ----------------------------------------------------------------------------
`include "integer_to_text_formatter_core_macros.svh"

module integer_to_text_formatter_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [itf_pkg::VALUE_W-1:0] value_i,
  input  logic                        is_signed_i,
  input  logic [1:0]                  radix_i,
  input  logic                        upper_case_i,
  input  logic [itf_pkg::WIDTH_W-1:0] field_width_i,
  input  logic                        left_align_i,
  input  logic                        plus_sign_i,
  input  logic                        zero_pad_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [itf_pkg::CHAR_W-1:0]  text_char_o,
  output logic                        last_char_o
);
  import itf_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  job_t push_job;
  job_t pop_job;

  itf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .is_signed_i  (is_signed_i),
    .radix_i      (radix_i),
    .upper_case_i (upper_case_i),
    .field_width_i(field_width_i),
    .left_align_i (left_align_i),
    .plus_sign_i  (plus_sign_i),
    .zero_pad_i   (zero_pad_i),
    .push_o       (q_push),
    .push_job_o   (push_job),
    .full_i       (q_full)
  );

  itf_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_job_i(push_job),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .pop_job_o (pop_job),
    .empty_o   (q_empty)
  );

  itf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_o      (q_pop),
    .pop_job_i  (pop_job),
    .empty_i    (q_empty),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .text_char_o(text_char_o),
    .last_char_o(last_char_o)
  );

  // A word taken in keeps the front end busy for at least the next cycle.
  `ITF_ASSERT_NXT(a_front_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `ITF_ASSERT_IMP(a_no_queue_overflow, clk_i, rst_ni, q_push, !q_full)
  `ITF_ASSERT_IMP(a_no_queue_underflow, clk_i, rst_ni, q_pop, !q_empty)

endmodule

### tb/sv/integer_to_text_formatter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer to text formatter checker
// Watches both channels of the formatter. Every number taken in is expanded
// into the field of characters it should produce. Every character sent out
// is compared with the oldest character still owed.
// ----------------------------------------------------------------------------
module integer_to_text_formatter_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [itf_pkg::VALUE_W-1:0] value_i,
  input  logic                        is_signed_i,
  input  logic [1:0]                  radix_i,
  input  logic                        upper_case_i,
  input  logic [itf_pkg::WIDTH_W-1:0] field_width_i,
  input  logic                        left_align_i,
  input  logic                        plus_sign_i,
  input  logic                        zero_pad_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [itf_pkg::CHAR_W-1:0]  text_char_i,
  input  logic                        last_char_i,
  output int                          fail_count_o,
  output int                          pending_chars_o,
  output int                          chars_checked_o
);

  import itf_pkg::*;

  localparam int DIGIT_LIMIT = 31;

  typedef struct packed {
    logic [CHAR_W-1:0] glyph;
    logic              last;
  } field_char_t;

  field_char_t expected_chars[$];

  // Expands one number into its padded field and queues the characters.
  function automatic void predict_field(input logic [VALUE_W-1:0] value,
                                        input logic sgn,
                                        input logic [1:0] radix,
                                        input logic upper,
                                        input logic [WIDTH_W-1:0] field_width,
                                        input logic left,
                                        input logic plus,
                                        input logic zpad);
    logic [VALUE_W-1:0] magnitude;
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] remainder;
    logic [CHAR_W-1:0]  digit_glyphs[0:DIGIT_LIMIT-1];
    logic [CHAR_W-1:0]  sign_glyph;
    logic [CHAR_W-1:0]  field[$];
    logic               neg;
    logic               has_sign;
    logic               zero_fill;
    int                 ndig;
    int                 width;
    int                 total;
    int                 npad;
    field_char_t        entry;

    width     = (field_width > MAX_FIELD_WIDTH) ? MAX_FIELD_WIDTH : int'(field_width);
    zero_fill = zpad && !left;
    magnitude = value;
    base      = 64'd10;
    neg       = 1'b0;
    has_sign  = 1'b0;
    sign_glyph = CHAR_PLUS;

    if (sgn) begin
      if (value[VALUE_W-1]) begin
        neg       = 1'b1;
        magnitude = -value;
      end
      has_sign   = neg || plus;
      sign_glyph = neg ? CHAR_MINUS : CHAR_PLUS;
    end else if (radix == RADIX_HEX) begin
      base = 64'd16;
    end else if (radix != RADIX_DEC) begin
      base = 64'd8;
    end

    // Digits are gathered least significant first.
    ndig = 0;
    do begin
      remainder = magnitude % base;
      if (remainder < 10) begin
        digit_glyphs[ndig] = CHAR_ZERO + CHAR_W'(remainder);
      end else if (upper) begin
        digit_glyphs[ndig] = CHAR_UP_A + CHAR_W'(remainder - 10);
      end else begin
        digit_glyphs[ndig] = CHAR_LOW_A + CHAR_W'(remainder - 10);
      end
      magnitude = magnitude / base;
      ndig++;
    end while (magnitude != 0 && ndig < DIGIT_LIMIT);

    total = ndig + (has_sign ? 1 : 0);
    if (width < total) width = total;
    npad = width - total;

    if (!left) begin
      if (has_sign && zero_fill) field.push_back(sign_glyph);
      repeat (npad) field.push_back(zero_fill ? CHAR_ZERO : CHAR_SPACE);
      if (has_sign && !zero_fill) field.push_back(sign_glyph);
      for (int i = ndig - 1; i >= 0; i--) field.push_back(digit_glyphs[i]);
    end else begin
      if (has_sign) field.push_back(sign_glyph);
      for (int i = ndig - 1; i >= 0; i--) field.push_back(digit_glyphs[i]);
      repeat (npad) field.push_back(CHAR_SPACE);
    end

    foreach (field[i]) begin
      entry.glyph = field[i];
      entry.last  = (i == field.size() - 1);
      expected_chars.push_back(entry);
    end
  endfunction

  always @(posedge clk_i) begin
    field_char_t owed;
    if (!rst_ni) begin
      fail_count_o    = 0;
      pending_chars_o = 0;
      chars_checked_o = 0;
      expected_chars.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        predict_field(value_i, is_signed_i, radix_i, upper_case_i, field_width_i,
                      left_align_i, plus_sign_i, zero_pad_i);
      end
      if (out_valid_i && !out_stall_i) begin
        chars_checked_o++;
        if (expected_chars.size() == 0) begin
          $error("character 8'h%02h arrived with none outstanding", text_char_i);
          fail_count_o++;
        end else begin
          owed = expected_chars.pop_front();
          if (text_char_i !== owed.glyph) begin
            $error("text_char mismatch: expected 8'h%02h, actual 8'h%02h",
                   owed.glyph, text_char_i);
            fail_count_o++;
          end
          if (last_char_i !== owed.last) begin
            $error("last_char mismatch: expected %0b, actual %0b", owed.last, last_char_i);
            fail_count_o++;
          end
        end
      end
      pending_chars_o = expected_chars.size();
    end
  end

endmodule

### tb/sv/integer_to_text_formatter_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer to text formatter testbench
// Feeds directed corner numbers and then random numbers with random flags to
// the formatter, with random gaps on the input and random holds on the
// output, and takes the verdict from the checker alongside.
// ----------------------------------------------------------------------------
module integer_to_text_formatter_core_test;

  import itf_pkg::*;

  localparam logic [1:0] RADIX_OCT   = 2'd2;
  localparam logic [1:0] RADIX_SPARE = 2'd3;

  localparam int RANDOM_ITEMS    = 150;
  localparam int QUIET_ITEMS     = 30;
  localparam int HOLD_OFF_AT     = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 40;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               sgn;
    logic [1:0]         radix;
    logic               upper;
    logic [WIDTH_W-1:0] width;
    logic               left;
    logic               plus;
    logic               zpad;
  } number_req_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [VALUE_W-1:0] value_i;
  logic               is_signed_i;
  logic [1:0]         radix_i;
  logic               upper_case_i;
  logic [WIDTH_W-1:0] field_width_i;
  logic               left_align_i;
  logic               plus_sign_i;
  logic               zero_pad_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [CHAR_W-1:0]  text_char_o;
  logic               last_char_o;

  int fail_count;
  int pending_chars;
  int chars_checked;
  int numbers_sent;
  bit quiet;
  bit hold_off_done;

  number_req_t corner_numbers[$];

  integer_to_text_formatter_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .is_signed_i  (is_signed_i),
    .radix_i      (radix_i),
    .upper_case_i (upper_case_i),
    .field_width_i(field_width_i),
    .left_align_i (left_align_i),
    .plus_sign_i  (plus_sign_i),
    .zero_pad_i   (zero_pad_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .text_char_o  (text_char_o),
    .last_char_o  (last_char_o)
  );

  integer_to_text_formatter_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .value_i        (value_i),
    .is_signed_i    (is_signed_i),
    .radix_i        (radix_i),
    .upper_case_i   (upper_case_i),
    .field_width_i  (field_width_i),
    .left_align_i   (left_align_i),
    .plus_sign_i    (plus_sign_i),
    .zero_pad_i     (zero_pad_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .text_char_i    (text_char_o),
    .last_char_i    (last_char_o),
    .fail_count_o   (fail_count),
    .pending_chars_o(pending_chars),
    .chars_checked_o(chars_checked)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic number_req_t make_number(input logic [VALUE_W-1:0] value,
                                              input int sgn,
                                              input logic [1:0] radix,
                                              input int upper,
                                              input int width,
                                              input int left,
                                              input int plus,
                                              input int zpad);
    number_req_t req;
    req.value = value;
    req.sgn   = 1'(sgn);
    req.radix = radix;
    req.upper = 1'(upper);
    req.width = WIDTH_W'(width);
    req.left  = 1'(left);
    req.plus  = 1'(plus);
    req.zpad  = 1'(zpad);
    return req;
  endfunction

  // A mix of zero, extreme, shifted-down and full-range values and mostly narrow
  // fields, with a wide or over-limit width now and then.
  function automatic number_req_t random_number();
    number_req_t req;
    logic [VALUE_W-1:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       req.value = '0;
      1:       req.value = $urandom_range(0, 1) ? {1'b1, {(VALUE_W-1){raw[0]}}}
                                                 : {1'b0, {(VALUE_W-1){1'b1}}};
      2, 3, 4, 5: req.value = raw >> $urandom_range(0, VALUE_W - 1);
      default: req.value = raw;
    endcase
    req.sgn = 1'($urandom_range(0, 1));
    if (req.sgn && $urandom_range(0, 1)) req.value = -req.value;
    req.radix = 2'($urandom_range(0, 3));
    req.upper = 1'($urandom_range(0, 1));
    req.width = ($urandom_range(0, 7) == 0) ? WIDTH_W'($urandom_range(0, 127))
                                            : WIDTH_W'($urandom_range(0, 24));
    req.left  = 1'($urandom_range(0, 1));
    req.plus  = 1'($urandom_range(0, 1));
    req.zpad  = 1'($urandom_range(0, 1));
    return req;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_number(input number_req_t req);
    in_valid_i    <= 1'b1;
    value_i       <= req.value;
    is_signed_i   <= req.sgn;
    radix_i       <= req.radix;
    upper_case_i  <= req.upper;
    field_width_i <= req.width;
    left_align_i  <= req.left;
    plus_sign_i   <= req.plus;
    zero_pad_i    <= req.zpad;
    do @(posedge clk_i); while (in_stall_o);
    numbers_sent++;
    @(negedge clk_i);
  endtask

  task automatic idle_input(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Output side: random holds in bands, one long hold-off once HOLD_OFF_AT numbers
  // have been sent, and none at all in the final stretch.
  initial begin
    out_stall_i   = 1'b0;
    hold_off_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        out_stall_i <= 1'b0;
      end else if (!hold_off_done && numbers_sent >= HOLD_OFF_AT) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        out_stall_i   <= 1'b0;
        hold_off_done = 1'b1;
      end else if ((numbers_sent / 25) % 2 == 0 && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    number_req_t req;
    int total_items;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    value_i       = '0;
    is_signed_i   = 1'b0;
    radix_i       = RADIX_DEC;
    upper_case_i  = 1'b0;
    field_width_i = '0;
    left_align_i  = 1'b0;
    plus_sign_i   = 1'b0;
    zero_pad_i    = 1'b0;
    numbers_sent  = 0;
    quiet         = 1'b0;

    corner_numbers.push_back(make_number('0, 0, RADIX_DEC, 0, 0, 0, 0, 0));
    corner_numbers.push_back(make_number('0, 1, RADIX_DEC, 0, 0, 0, 0, 0));
    corner_numbers.push_back(make_number('1, 0, RADIX_DEC, 0, 0, 0, 0, 0));
    corner_numbers.push_back(make_number('1, 0, RADIX_HEX, 0, 0, 0, 0, 0));
    corner_numbers.push_back(make_number('1, 0, RADIX_HEX, 1, 20, 0, 0, 1));
    corner_numbers.push_back(make_number('1, 0, RADIX_OCT, 0, 0, 0, 0, 0));
    corner_numbers.push_back(make_number(64'o1234567, 0, RADIX_SPARE, 1, 9, 0, 0, 1));
    // The most negative value must print in full.
    corner_numbers.push_back(make_number(64'h8000_0000_0000_0000, 1, RADIX_DEC, 0, 0, 0, 0, 0));
    corner_numbers.push_back(make_number('1, 1, RADIX_DEC, 0, 5, 0, 0, 1));
    corner_numbers.push_back(make_number(64'h7FFF_FFFF_FFFF_FFFF, 1, RADIX_DEC, 0, 64, 0, 1, 1));
    corner_numbers.push_back(make_number(64'd42, 1, RADIX_DEC, 0, 6, 0, 1, 0));
    corner_numbers.push_back(make_number(-64'd42, 1, RADIX_DEC, 0, 6, 1, 0, 1));
    corner_numbers.push_back(make_number(64'd255, 0, RADIX_HEX, 1, 127, 0, 0, 0));
    corner_numbers.push_back(make_number(64'd12345, 0, RADIX_DEC, 0, 100, 1, 0, 0));
    corner_numbers.push_back(make_number(64'd1234567, 1, RADIX_DEC, 0, 1, 0, 1, 0));
    corner_numbers.push_back(make_number(64'd7, 0, RADIX_DEC, 1, 3, 0, 1, 0));
    corner_numbers.push_back(make_number(64'd255, 1, RADIX_HEX, 1, 0, 0, 0, 0));
    corner_numbers.push_back(make_number(-64'd5, 1, RADIX_DEC, 0, 64, 1, 0, 0));
    corner_numbers.push_back(make_number(64'hDEAD_BEEF, 0, RADIX_HEX, 0, 8, 0, 0, 1));
    corner_numbers.push_back(make_number('0, 1, RADIX_DEC, 0, 4, 0, 1, 1));
    corner_numbers.push_back(make_number(64'd8, 0, RADIX_OCT, 0, 3, 0, 0, 1));
    corner_numbers.push_back(make_number(64'hFEDC_BA98_7654_3210, 0, RADIX_HEX, 1, 65, 1, 1, 1));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (corner_numbers[i]) begin
      send_number(corner_numbers[i]);
    end

    total_items = corner_numbers.size() + RANDOM_ITEMS;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (numbers_sent >= total_items - QUIET_ITEMS) quiet = 1'b1;
      if (!quiet && (i / 20) % 2 == 0 && $urandom_range(0, 3) == 0) begin
        idle_input($urandom_range(1, 13));
      end
      req = random_number();
      send_number(req);
    end
    in_valid_i <= 1'b0;
    quiet = 1'b1;

    while (pending_chars != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Formatted %0d numbers into %0d checked characters across all radices,",
             numbers_sent, chars_checked);
    $display("with corner values, over-limit widths and a %0d-cycle output hold-off.",
             HOLD_OFF_CYCLES);
    if (fail_count == 0) begin
      $display("integer_to_text_formatter_core_test passed");
    end else begin
      $display("integer_to_text_formatter_core_test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("integer_to_text_formatter_core_test failed");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/itf_pkg.sv
sv/itf_front.sv
sv/itf_queue.sv
sv/itf_back.sv
sv/integer_to_text_formatter_core.sv
tb/sv/integer_to_text_formatter_checker.sv
tb/sv/integer_to_text_formatter_core_test.sv
